>>> hw/rtl/iirld_pkg.sv
// shared types and constants for the low-pass decimator with gain
`timescale 1ns / 1ps
`default_nettype none
package iirld_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefW    = 31;
  localparam int unsigned FactorW  = 8;
  localparam int unsigned GainW    = 31;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned DefStages    = 4;
  localparam int unsigned DefGainShift = 12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LPF_COEF = 2'd0,
    REG_DECIM    = 2'd1,
    REG_GAIN     = 2'd2
  } cfg_reg_e;

  // one sample moving down the chain
  typedef struct packed {
    logic                      valid;
    logic signed [SampleW-1:0] sample;
  } tok_t;

endpackage
`default_nettype wire

>>> hw/rtl/iir_lowpass_decimator_with_gain.sv
// top level: cascaded one-pole low-pass, one-in-n decimation and output gain
//
// input channel in_valid_i / in_stall_o / in_sample_i, output channel
// out_valid_o / out_stall_i / out_sample_o; a transfer happens at a clock
// edge with valid high and stall low. registers are written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must do so only while no
// sample is in flight, as the block itself does not enforce it.
// an accepted sample enters a front register, then walks the row of STAGES
// filter cells one cell per cycle, then the gain multiplier and the
// saturating output register. one sample is in flight at a time: the next
// sample is taken once a kept one moves from the product register to the
// output register, or once a dropped one leaves the cell row (the front
// register in bypass, when the decimation factor is 1). a finished result
// waits in the output register; the next sample is taken meanwhile, but its
// result waits in the product register while out_stall_i stays high, and
// in_stall_o stays high with it.
// reset clears the cell memories and the keep counter and loads the default
// registers: coefficient 0, factor 1, gain 2^GAIN_SHIFT.
`timescale 1ns / 1ps
`default_nettype none
module iir_lowpass_decimator_with_gain
  import iirld_pkg::*;
#(
  parameter int unsigned STAGES     = DefStages,
  parameter int unsigned GAIN_SHIFT = DefGainShift
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [CfgDataW-1:0]       cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [SampleW-1:0] in_sample_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [SampleW-1:0]      out_sample_o
);

  localparam logic [GainW-1:0] GainReset = GainW'(64'd1 << GAIN_SHIFT);

  logic [CoefW-1:0]   coef_q;
  logic [FactorW-1:0] factor_q;
  logic [GainW-1:0]   gain_q;
  logic [FactorW-1:0] cnt_q, cnt_d, cnt_next;
  logic               busy_q, busy_d;
  logic               keep_q, keep_d;
  logic               bypass_q, bypass_d;
  tok_t               front_q, front_d;
  tok_t               chain [STAGES+1];
  tok_t               gain_tok;
  logic               gain_done;
  logic               drop;
  logic               accept;

  assign accept   = in_valid_i && !busy_q;
  assign cnt_next = cnt_q + FactorW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      factor_q <= FactorW'(1);
      gain_q   <= GainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LPF_COEF: coef_q   <= cfg_wdata_i[CoefW-1:0];
        REG_DECIM:    factor_q <= cfg_wdata_i[FactorW-1:0];
        REG_GAIN:     gain_q   <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign chain[0].valid  = front_q.valid && !bypass_q;
  assign chain[0].sample = front_q.sample;

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    iirld_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .coef_i (coef_q),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  // the sample reaching the gain stage comes from the front in bypass, else the chain end
  always_comb begin
    gain_tok = chain[STAGES];
    drop     = 1'b0;
    if (front_q.valid && bypass_q) begin
      gain_tok.valid  = keep_q;
      gain_tok.sample = front_q.sample;
      drop            = !keep_q;
    end else begin
      gain_tok.valid = chain[STAGES].valid && keep_q;
      drop           = chain[STAGES].valid && !keep_q;
    end
  end

  iirld_gain #(
    .GAIN_SHIFT (GAIN_SHIFT)
  ) u_gain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gain_i       (gain_q),
    .tok_i        (gain_tok),
    .done_o       (gain_done),
    .out_valid_o  (out_valid_o),
    .out_sample_o (out_sample_o),
    .out_stall_i  (out_stall_i)
  );

  always_comb begin
    cnt_d          = cnt_q;
    busy_d         = busy_q;
    keep_d         = keep_q;
    bypass_d       = bypass_q;
    front_d.valid  = 1'b0;
    front_d.sample = front_q.sample;
    if (drop || gain_done) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d         = 1'b1;
      front_d.valid  = 1'b1;
      front_d.sample = in_sample_i;
      bypass_d       = (factor_q == FactorW'(1));
      keep_d         = (cnt_next == factor_q);
      cnt_d          = (cnt_next == factor_q) ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      keep_q   <= 1'b0;
      bypass_q <= 1'b0;
      front_q  <= '0;
    end else begin
      cnt_q    <= cnt_d;
      busy_q   <= busy_d;
      keep_q   <= keep_d;
      bypass_q <= bypass_d;
      front_q  <= front_d;
    end
  end

  assign in_stall_o = busy_q;

endmodule
`default_nettype wire

>>> hw/rtl/iirld_cell.sv
// one one-pole low-pass cell: holds its last output and passes the result on
`timescale 1ns / 1ps
`default_nettype none
module iirld_cell
  import iirld_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CoefW-1:0] coef_i,
  input  wire tok_t             tok_i,
  output tok_t                  tok_o
);

  localparam int unsigned ProdW = SampleW + 1 + CoefW + 1;

  logic signed [SampleW-1:0] prev_q, prev_d;
  tok_t                      tok_q, tok_d;
  logic signed [SampleW:0]   diff;
  logic signed [ProdW-1:0]   diff_x, coef_x, prod, shifted;
  logic signed [SampleW-1:0] y;

  // c*x + (1-c)*prev == prev + c*(x - prev), floor is exact after adding prev
  assign diff    = (SampleW + 1)'(tok_i.sample) - (SampleW + 1)'(prev_q);
  assign diff_x  = ProdW'(diff);
  assign coef_x  = $signed({{(ProdW - CoefW){1'b0}}, coef_i});
  assign prod    = diff_x * coef_x;
  assign shifted = prod >>> (CoefW);
  assign y       = prev_q + shifted[SampleW-1:0];

  always_comb begin
    prev_d       = prev_q;
    tok_d.valid  = tok_i.valid;
    tok_d.sample = tok_q.sample;
    if (tok_i.valid) begin
      prev_d       = y;
      tok_d.sample = y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      tok_q  <= '0;
    end else begin
      prev_q <= prev_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

>>> hw/rtl/iirld_gain.sv
// output gain: product register, then shift, saturate and output register
`timescale 1ns / 1ps
`default_nettype none
module iirld_gain
  import iirld_pkg::*;
#(
  parameter int unsigned GAIN_SHIFT = DefGainShift
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [GainW-1:0]          gain_i,
  input  wire tok_t                      tok_i,
  output logic                           done_o,
  output logic                           out_valid_o,
  output logic signed [SampleW-1:0]      out_sample_o,
  input  wire logic                      out_stall_i
);

  localparam int unsigned ProdW = SampleW + GainW + 1;
  localparam logic signed [ProdW-1:0] SatMax = ProdW'(signed'(2 ** (SampleW - 1) - 1));
  localparam logic signed [ProdW-1:0] SatMin = -ProdW'(signed'(2 ** (SampleW - 1)));

  logic                      prod_valid_q, prod_valid_d;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] out_q, out_d;
  logic signed [ProdW-1:0]   x_x, gain_x, shifted;
  logic signed [SampleW-1:0] sat;
  logic                      move;

  assign x_x    = ProdW'(tok_i.sample);
  assign gain_x = $signed({{(ProdW - GainW){1'b0}}, gain_i});

  assign shifted = prod_q >>> GAIN_SHIFT;

  always_comb begin
    if (shifted > SatMax) begin
      sat = SatMax[SampleW-1:0];
    end else if (shifted < SatMin) begin
      sat = SatMin[SampleW-1:0];
    end else begin
      sat = shifted[SampleW-1:0];
    end
  end

  // the product moves on once the output register is free or being drained
  assign move = prod_valid_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    prod_valid_d = prod_valid_q;
    prod_d       = prod_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (move) begin
      prod_valid_d = 1'b0;
      out_valid_d  = 1'b1;
      out_d        = sat;
    end
    if (tok_i.valid) begin
      prod_valid_d = 1'b1;
      prod_d       = x_x * gain_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= prod_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign done_o       = move;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

endmodule
`default_nettype wire

>>> hw/rtl/iirld_checker.sv
// port-level checks for the low-pass decimator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module iirld_checker
  import iirld_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic signed [SampleW-1:0] out_sample_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_sample_o))
    else $error("result changed while stalled");

  // one sample at a time: a transfer closes the input until it is done
  a_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input open right after a transfer");

  // no result appears in the cycle after an input transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_xfer))
    else $error("result too early after input transfer");

endmodule

bind iir_lowpass_decimator_with_gain iirld_checker u_iirld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_sample_o (out_sample_o)
);
`default_nettype wire
